// File: hw/rtl/hsd_pkg.sv
// ----------------------------------------------------------------------------
// Hall sensor decoder package
// Shared constants, field layouts, state codes and angle helpers for the
// hall sensor decoder and its checker.
// ----------------------------------------------------------------------------
package hsd_pkg;

    // Capture counter and stream widths
    localparam int CountWidth  = 16;
    localparam int HallWidth   = 3;
    localparam int AngleWidth  = 9;
    localparam int SpeedWidth  = 33;
    localparam int QuoWidth    = 32;
    localparam int FracWidth   = 16;
    localparam int EntryWidth  = 10;
    localparam int TableWidth  = 40;
    localparam int ScaleWidth  = 32;
    localparam int InDataWidth = 24;
    localparam int OutDataWidth = 64;
    localparam int CfgIdxWidth = 2;
    localparam int CntWidth    = $clog2(QuoWidth);

    // Output tdata bit positions, lowest field first
    localparam int OutHallLo  = 0;
    localparam int OutRotLo   = OutHallLo + HallWidth;
    localparam int OutAngLo   = OutRotLo + 2;
    localparam int OutSpdLo   = OutAngLo + AngleWidth;
    localparam int OutDlyLo   = OutSpdLo + SpeedWidth;
    localparam int OutStallLo = OutDlyLo + CountWidth;

    // Input tdata bit positions
    localparam int InHallLo  = 0;
    localparam int InCountLo = InHallLo + HallWidth;

    // Input kinds carried in tuser
    localparam logic CmdEdge     = 1'b0;
    localparam logic CmdOverflow = 1'b1;

    // Configuration register indexes
    localparam logic [CfgIdxWidth-1:0] CfgAnglesLo = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CfgAnglesHi = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CfgDelay    = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CfgScale    = 2'd3;

    // Rotation codes
    localparam logic signed [1:0] RotNone = 2'sb00;
    localparam logic signed [1:0] RotCw   = 2'sb01;
    localparam logic signed [1:0] RotCcw  = 2'sb11;

    localparam logic [AngleWidth-1:0] Deg360 = 9'd360;
    localparam logic [AngleWidth-1:0] Deg60  = 9'd60;
    localparam logic [QuoWidth-1:0]   QuoSat = '1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECODE = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_DONE   = 4'b1000
    } t_state;

    // Fold a raw 9-bit angle into 0..359.
    function automatic logic [AngleWidth-1:0] reduce360(input logic [AngleWidth-1:0] a);
        reduce360 = (a >= Deg360) ? a - Deg360 : a;
    endfunction

    // Add 60 degrees modulo 360 to an angle already in range.
    function automatic logic [AngleWidth-1:0] plus60(input logic [AngleWidth-1:0] a);
        logic [AngleWidth:0] s;
        s = {1'b0, a} + {1'b0, Deg60};
        plus60 = (s >= {1'b0, Deg360}) ? AngleWidth'(s - {1'b0, Deg360}) : s[AngleWidth-1:0];
    endfunction

    // Pick the 10-bit entry of one hall state out of both angle registers.
    function automatic logic [EntryWidth-1:0] table_entry(
        input logic [2*TableWidth-1:0] tbl,
        input logic [HallWidth-1:0]    hs
    );
        table_entry = tbl[7'(hs) * 7'(EntryWidth) +: EntryWidth];
    endfunction

endpackage

// File: hw/rtl/hall_sensor_decoder_top.sv
// An input item passes ST_DECODE, then ST_DIVIDE when the speed quotient is
// computed (32 divider iterations), then ST_DONE, which waits for a free output
// register. One item at a time: the next input is taken only back in ST_IDLE.
// Speed uses a bit-serial restoring divider. Reset is synchronous, active low;
// it clears the state, output valid, hall, period and config registers and sets stall.
// ----------------------------------------------------------------------------
// Hall sensor decoder top level
// Tracks the hall state and period, decodes direction and rotor angle from
// the configured angle map, and computes speed and commutation delay.
// ----------------------------------------------------------------------------
module hall_sensor_decoder_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hsd_pkg::CfgIdxWidth-1:0]  i_cfg_index,
    input  logic [hsd_pkg::TableWidth-1:0]   i_cfg_data,
    // Input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [2:0] hall_bits, [18:3] capture_count, [23:19] zero
    input  logic [hsd_pkg::InDataWidth-1:0]  s_axis_tdata,
    // [0] cmd
    input  logic                             s_axis_tuser,
    // Output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] hall_now, [4:3] rotation, [13:5] angle_deg, [46:14] speed_radps,
    // [62:47] comm_delay, [63] stalled
    output logic [hsd_pkg::OutDataWidth-1:0] m_axis_tdata
);

    // Configuration registers
    logic [hsd_pkg::TableWidth-1:0] r_ang_lo, r_ang_hi;
    logic [hsd_pkg::FracWidth-1:0]  r_delay_frac;
    logic [hsd_pkg::ScaleWidth-1:0] r_scale;

    // Decoder state
    logic [hsd_pkg::HallWidth-1:0]  r_hall_cur, r_hall_prev, n_hall_cur, n_hall_prev;
    logic [hsd_pkg::CountWidth-1:0] r_period, n_period;
    logic                           r_stall, n_stall;

    // Sequencer and datapath registers
    hsd_pkg::t_state                r_state, n_state;
    logic signed [1:0]              r_rot, n_rot;
    logic [hsd_pkg::AngleWidth-1:0] r_angle, n_angle;
    logic [hsd_pkg::CountWidth-1:0] r_delay, n_delay;
    logic [hsd_pkg::QuoWidth-1:0]   r_quo, n_quo;
    logic [hsd_pkg::CountWidth-1:0] r_rem, n_rem;
    logic [hsd_pkg::CntWidth-1:0]   r_cnt, n_cnt;
    logic                           r_out_valid, n_out_valid;
    logic [hsd_pkg::OutDataWidth-1:0] r_out_data, n_out_data;

    logic in_xfer, out_xfer;
    logic [2*hsd_pkg::CountWidth-1:0] dly_prod;
    logic [hsd_pkg::EntryWidth-1:0]   ent_p, ent_c;
    logic [hsd_pkg::AngleWidth-1:0]   ap, ac, ap60, ac60;
    logic signed [1:0]                dir;
    logic [hsd_pkg::AngleWidth-1:0]   dir_angle;
    logic [hsd_pkg::CountWidth:0]     rem_sh, rem_diff;
    logic                             quo_bit;
    logic [hsd_pkg::SpeedWidth-1:0]   speed;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == hsd_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = r_out_valid && m_axis_tready;

    // Commutation delay product, taken at the input transfer
    assign dly_prod =
        {{hsd_pkg::CountWidth{1'b0}}, s_axis_tdata[hsd_pkg::InCountLo +: hsd_pkg::CountWidth]} *
        {{(2*hsd_pkg::CountWidth-hsd_pkg::FracWidth){1'b0}}, r_delay_frac};

    // Direction decode from the angle map of the previous and current states
    always_comb begin
        ent_p = hsd_pkg::table_entry({r_ang_hi, r_ang_lo}, r_hall_prev);
        ent_c = hsd_pkg::table_entry({r_ang_hi, r_ang_lo}, r_hall_cur);
        ap    = hsd_pkg::reduce360(ent_p[hsd_pkg::AngleWidth-1:0]);
        ac    = hsd_pkg::reduce360(ent_c[hsd_pkg::AngleWidth-1:0]);
        ap60  = hsd_pkg::plus60(ap);
        ac60  = hsd_pkg::plus60(ac);
        dir       = hsd_pkg::RotNone;
        dir_angle = '0;
        if (ent_p[hsd_pkg::AngleWidth] && ent_c[hsd_pkg::AngleWidth]) begin
            if (ap60 == ac) begin
                dir       = hsd_pkg::RotCw;
                dir_angle = ac;
            end else if (ac60 == ap) begin
                dir       = hsd_pkg::RotCcw;
                dir_angle = ac60;
            end
        end
    end

    // One restoring divider step: shift in a dividend bit, try to subtract
    always_comb begin
        rem_sh   = {r_rem, r_quo[hsd_pkg::QuoWidth-1]};
        rem_diff = rem_sh - {1'b0, r_period};
        quo_bit  = (rem_sh >= {1'b0, r_period});
    end

    // Signed speed from the rotation and the unsigned quotient
    always_comb begin
        case (r_rot)
            hsd_pkg::RotCw:  speed = {1'b0, r_quo};
            hsd_pkg::RotCcw: speed = hsd_pkg::SpeedWidth'(0) - {1'b0, r_quo};
            default:         speed = '0;
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_hall_cur  = r_hall_cur;
        n_hall_prev = r_hall_prev;
        n_period    = r_period;
        n_stall     = r_stall;
        n_rot       = r_rot;
        n_angle     = r_angle;
        n_delay     = r_delay;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !out_xfer;
        n_out_data  = r_out_data;
        case (r_state)
            hsd_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (s_axis_tuser == hsd_pkg::CmdEdge) begin
                        n_hall_prev = r_hall_cur;
                        n_hall_cur  = s_axis_tdata[hsd_pkg::InHallLo +: hsd_pkg::HallWidth];
                        n_period    = s_axis_tdata[hsd_pkg::InCountLo +: hsd_pkg::CountWidth];
                        n_stall     = 1'b0;
                        n_delay     = dly_prod[hsd_pkg::FracWidth +: hsd_pkg::CountWidth];
                    end else begin
                        n_stall = 1'b1;
                        n_delay = '0;
                    end
                    n_state = hsd_pkg::ST_DECODE;
                end
            end
            hsd_pkg::ST_DECODE: begin
                n_angle = dir_angle;
                n_rot   = r_stall ? hsd_pkg::RotNone : dir;
                n_rem   = '0;
                n_cnt   = '0;
                if (r_stall || dir == hsd_pkg::RotNone) begin
                    n_quo   = '0;
                    n_state = hsd_pkg::ST_DONE;
                end else if (r_period == '0) begin
                    n_quo   = hsd_pkg::QuoSat;
                    n_state = hsd_pkg::ST_DONE;
                end else begin
                    n_quo   = r_scale;
                    n_state = hsd_pkg::ST_DIVIDE;
                end
            end
            hsd_pkg::ST_DIVIDE: begin
                n_rem = quo_bit ? rem_diff[hsd_pkg::CountWidth-1:0]
                                : rem_sh[hsd_pkg::CountWidth-1:0];
                n_quo = {r_quo[hsd_pkg::QuoWidth-2:0], quo_bit};
                n_cnt = r_cnt + hsd_pkg::CntWidth'(1);
                if (r_cnt == hsd_pkg::CntWidth'(hsd_pkg::QuoWidth - 1)) begin
                    n_state = hsd_pkg::ST_DONE;
                end
            end
            hsd_pkg::ST_DONE: begin
                // Load the result once the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_stall, r_delay, speed, r_angle, r_rot, r_hall_cur};
                    n_state     = hsd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hsd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hsd_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_hall_cur  <= '0;
            r_hall_prev <= '0;
            r_period    <= '0;
            r_stall     <= 1'b1;
            r_ang_lo    <= '0;
            r_ang_hi    <= '0;
            r_delay_frac <= '0;
            r_scale     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_hall_cur  <= n_hall_cur;
            r_hall_prev <= n_hall_prev;
            r_period    <= n_period;
            r_stall     <= n_stall;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    hsd_pkg::CfgAnglesLo: r_ang_lo <= i_cfg_data;
                    hsd_pkg::CfgAnglesHi: r_ang_hi <= i_cfg_data;
                    hsd_pkg::CfgDelay:    r_delay_frac <= i_cfg_data[hsd_pkg::FracWidth-1:0];
                    hsd_pkg::CfgScale:    r_scale <= i_cfg_data[hsd_pkg::ScaleWidth-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rot      <= n_rot;
        r_angle    <= n_angle;
        r_delay    <= n_delay;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_out_data <= n_out_data;
    end

endmodule

// File: hw/rtl/hsd_checker.sv
// ----------------------------------------------------------------------------
// Hall sensor decoder checker
// Port-level assertions on the decoder's streams, bound to the top level.
// ----------------------------------------------------------------------------
module hsd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [hsd_pkg::OutDataWidth-1:0] m_axis_tdata
);

    logic signed [1:0]                out_rot;
    logic [hsd_pkg::AngleWidth-1:0]   out_angle;
    logic [hsd_pkg::SpeedWidth-1:0]   out_speed;
    logic                             out_stall;

    assign out_rot   = m_axis_tdata[hsd_pkg::OutRotLo +: 2];
    assign out_angle = m_axis_tdata[hsd_pkg::OutAngLo +: hsd_pkg::AngleWidth];
    assign out_speed = m_axis_tdata[hsd_pkg::OutSpdLo +: hsd_pkg::SpeedWidth];
    assign out_stall = m_axis_tdata[hsd_pkg::OutStallLo];

    // The block works on one item at a time: after a transfer it stops taking input.
    a_busy_after_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // A stalled result, or one without direction, carries no speed.
    a_no_speed_without_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (out_stall || out_rot == hsd_pkg::RotNone) |-> out_speed == '0)
        else $error("speed nonzero without rotation");

    // Stalled results never report a rotation.
    a_stall_no_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_stall |-> out_rot == hsd_pkg::RotNone)
        else $error("rotation reported while stalled");

    // Angles are always folded into one turn.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> out_angle < hsd_pkg::Deg360)
        else $error("angle out of range");

    // A held result keeps its data until it is taken.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed before transfer");

endmodule

bind hall_sensor_decoder_top hsd_checker u_hsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
